[src/jsu_pkg.sv]
// Package for the JSON string unescape block.
// Holds the decode mode and result kind types, the result bundle and character codes.
// No dependencies.
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX     = 3'd2,
        MODE_SURR1   = 3'd3,
        MODE_SURR2   = 3'd4,
        MODE_SWALLOW = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [1:0]      count;
        t_kind           kind;
        logic [2:0][7:0] bytes;
    } t_bundle;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_QMARK     = 8'h3F;
    localparam logic [7:0] CH_LC_B      = 8'h62;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_LC_N      = 8'h6E;
    localparam logic [7:0] CH_LC_R      = 8'h72;
    localparam logic [7:0] CH_LC_T      = 8'h74;
    localparam logic [7:0] CH_LC_U      = 8'h75;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] CTL_BS       = 8'h08;
    localparam logic [7:0] CTL_FF       = 8'h0C;
    localparam logic [7:0] CTL_LF       = 8'h0A;
    localparam logic [7:0] CTL_CR       = 8'h0D;
    localparam logic [7:0] CTL_TAB      = 8'h09;

    localparam logic [15:0] CAP_RESET   = 16'd2048;
    localparam logic [1:0]  REG_CAPACITY = 2'd0;

endpackage

`default_nettype wire

[src/jsu_decode.sv]
// Decode logic for one source byte of the JSON string unescape block.
// Gives next decoder state and the bundle of up to three results for that byte.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire jsu_pkg::t_mode          i_mode,
    input  wire logic [15:0]             i_code,
    input  wire logic [2:0]              i_digits,
    input  wire logic [COUNT_WIDTH-1:0]  i_written,
    input  wire logic [COUNT_WIDTH-1:0]  i_source,
    input  wire logic [15:0]             i_capacity,
    input  wire logic                    i_action,
    input  wire logic [7:0]              i_byte,
    output jsu_pkg::t_mode               o_mode,
    output logic [15:0]                  o_code,
    output logic [2:0]                   o_digits,
    output logic [COUNT_WIDTH-1:0]       o_written,
    output logic [COUNT_WIDTH-1:0]       o_source,
    output jsu_pkg::t_bundle             o_bundle,
    output logic [15:0]                  o_out_length,
    output logic [15:0]                  o_consumed
);

    localparam int CMPW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // {known, is_u, byte}
    function automatic logic [9:0] esc_map(input logic [7:0] e);
        logic [9:0] r;
        r = 10'd0;
        case (e)
            jsu_pkg::CH_QUOTE:     r = {2'b10, jsu_pkg::CH_QUOTE};
            jsu_pkg::CH_BACKSLASH: r = {2'b10, jsu_pkg::CH_BACKSLASH};
            jsu_pkg::CH_SLASH:     r = {2'b10, jsu_pkg::CH_SLASH};
            jsu_pkg::CH_LC_B:      r = {2'b10, jsu_pkg::CTL_BS};
            jsu_pkg::CH_LC_F:      r = {2'b10, jsu_pkg::CTL_FF};
            jsu_pkg::CH_LC_N:      r = {2'b10, jsu_pkg::CTL_LF};
            jsu_pkg::CH_LC_R:      r = {2'b10, jsu_pkg::CTL_CR};
            jsu_pkg::CH_LC_T:      r = {2'b10, jsu_pkg::CTL_TAB};
            jsu_pkg::CH_LC_U:      r = {2'b01, 8'd0};
            default:               r = 10'd0;
        endcase
        return r;
    endfunction

    logic                   no_room;
    logic [COUNT_WIDTH-1:0] src_inc;
    logic [COUNT_WIDTH+1:0] wsum;
    logic                   plain_path;
    logic                   esc_path;
    logic                   err;
    logic                   done;
    logic [1:0]             n_emit;
    logic [2:0][7:0]        bytes;
    logic [9:0]             esc;
    logic [3:0]             hex_d;
    logic                   hex_ok;
    logic [15:0]            cp;
    logic [2:0]             dig;

    assign no_room = (CMPW'(i_written) + CMPW'(4)) >= CMPW'(i_capacity);
    assign src_inc = (i_source == COUNT_MAX) ? COUNT_MAX : i_source + COUNT_WIDTH'(1);

    always_comb begin
        o_mode     = i_mode;
        o_code     = i_code;
        o_digits   = i_digits;
        plain_path = 1'b0;
        esc_path   = 1'b0;
        err        = 1'b0;
        done       = 1'b0;
        n_emit     = 2'd0;
        bytes      = '0;
        esc        = esc_map(i_byte);
        hex_d      = 4'd0;
        hex_ok     = 1'b1;
        cp         = {i_code[11:0], 4'd0};
        dig        = i_digits + 3'd1;

        if (i_byte inside {[jsu_pkg::CH_0:jsu_pkg::CH_9]}) begin
            hex_d = 4'(i_byte - jsu_pkg::CH_0);
        end else if (i_byte inside {[jsu_pkg::CH_LC_A:jsu_pkg::CH_LC_F]}) begin
            hex_d = 4'(i_byte - jsu_pkg::CH_LC_A + 8'd10);
        end else if (i_byte inside {[jsu_pkg::CH_UC_A:jsu_pkg::CH_UC_F]}) begin
            hex_d = 4'(i_byte - jsu_pkg::CH_UC_A + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
        cp = {i_code[11:0], hex_d};

        case (i_mode)
            jsu_pkg::MODE_ESC: begin
                esc_path = 1'b1;
            end
            jsu_pkg::MODE_HEX: begin
                if (!hex_ok) begin
                    err = 1'b1;
                end else begin
                    o_code   = cp;
                    o_digits = dig;
                    if (dig[2]) begin
                        o_digits = 3'd0;
                        o_mode   = jsu_pkg::MODE_PLAIN;
                        if (cp[15:11] == 5'b11011) begin
                            n_emit   = 2'd1;
                            bytes[0] = jsu_pkg::CH_QMARK;
                            if (!cp[10]) begin
                                o_mode = jsu_pkg::MODE_SURR1;
                            end
                        end else if (cp[15:7] == 9'd0) begin
                            n_emit   = 2'd1;
                            bytes[0] = cp[7:0];
                        end else if (cp[15:11] == 5'd0) begin
                            n_emit   = 2'd2;
                            bytes[0] = {3'b110, cp[10:6]};
                            bytes[1] = {2'b10, cp[5:0]};
                        end else begin
                            n_emit   = 2'd3;
                            bytes[0] = {4'b1110, cp[15:12]};
                            bytes[1] = {2'b10, cp[11:6]};
                            bytes[2] = {2'b10, cp[5:0]};
                        end
                    end
                end
            end
            jsu_pkg::MODE_SURR1: begin
                if (i_byte == jsu_pkg::CH_BACKSLASH) begin
                    o_mode = jsu_pkg::MODE_SURR2;
                end else begin
                    plain_path = 1'b1;
                end
            end
            jsu_pkg::MODE_SURR2: begin
                if (i_byte == jsu_pkg::CH_LC_U) begin
                    o_mode   = jsu_pkg::MODE_SWALLOW;
                    o_digits = 3'd0;
                end else if (no_room) begin
                    err = 1'b1;
                end else begin
                    esc_path = 1'b1;
                end
            end
            jsu_pkg::MODE_SWALLOW: begin
                o_digits = dig;
                if (dig[2]) begin
                    o_digits = 3'd0;
                    o_mode   = jsu_pkg::MODE_PLAIN;
                end
            end
            default: begin
                plain_path = 1'b1;
            end
        endcase

        if (plain_path) begin
            o_mode = jsu_pkg::MODE_PLAIN;
            if (i_byte == jsu_pkg::CH_QUOTE) begin
                done = 1'b1;
            end else if (no_room) begin
                err = 1'b1;
            end else if (i_byte == jsu_pkg::CH_BACKSLASH) begin
                o_mode = jsu_pkg::MODE_ESC;
            end else begin
                n_emit   = 2'd1;
                bytes[0] = i_byte;
            end
        end

        if (esc_path) begin
            o_mode = jsu_pkg::MODE_PLAIN;
            if (esc[9]) begin
                n_emit   = 2'd1;
                bytes[0] = esc[7:0];
            end else if (esc[8]) begin
                o_mode   = jsu_pkg::MODE_HEX;
                o_code   = 16'd0;
                o_digits = 3'd0;
            end else begin
                err = 1'b1;
            end
        end

        if (i_action) begin
            err  = 1'b1;
            done = 1'b0;
        end

        wsum      = {2'b00, i_written} + (COUNT_WIDTH+2)'(n_emit);
        o_written = (wsum > (COUNT_WIDTH+2)'(COUNT_MAX)) ? COUNT_MAX : wsum[COUNT_WIDTH-1:0];
        o_source  = i_action ? i_source : src_inc;

        o_bundle.count = n_emit;
        o_bundle.kind  = jsu_pkg::KIND_DATA;
        o_bundle.bytes = bytes;
        o_out_length   = 16'd0;
        o_consumed     = 16'd0;

        if (err || done) begin
            o_mode         = jsu_pkg::MODE_PLAIN;
            o_code         = 16'd0;
            o_digits       = 3'd0;
            o_written      = '0;
            o_source       = '0;
            o_bundle.count = 2'd1;
            o_bundle.bytes = '0;
            o_bundle.kind  = err ? jsu_pkg::KIND_ERR : jsu_pkg::KIND_DONE;
            if (done) begin
                o_out_length = 16'(i_written);
                o_consumed   = 16'(src_inc);
            end
        end
    end

endmodule

`default_nettype wire

[src/json_string_unescape.sv]
// JSON string unescape block: decodes a JSON string body into UTF-8 bytes.
// Depends on jsu_pkg and jsu_decode.
//
// Input stream: one request per source byte, tdata = src_byte, tuser = action
// (high when the source ended with no byte). Start just after the opening quote.
// Output stream: tuser = kind (data, done, error), tdata = out_byte, out_length,
// consumed_count from the lowest bit up, tlast marks the last result of a request.
// Each request gives zero to three results; a done or error result returns the
// decoder to its start state with counts at zero.
// Results of a request are registered and appear in the cycle after it is taken.
// Throughput: one request per cycle while each gives at most one result and the receiver
// is ready; a request giving more results holds the input until its last result leaves,
// as the single output register drains the result bundle one entry per cycle.
// When the receiver stalls the bundle holds and the input is taken again as soon
// as the last pending result leaves.
// Reset (synchronous, active low) clears the decoder and sets out_capacity to 2048.
// Configuration: APB register 0 at address 0 is out_capacity; write only when idle.
`default_nettype none

module json_string_unescape #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // src_byte
    input  wire logic        i_s_tuser,   // action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // out_byte, out_length, consumed_count
    output logic [1:0]       o_m_tuser,   // kind
    output logic             o_m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    jsu_pkg::t_mode         r_mode;
    logic [15:0]            r_code;
    logic [2:0]             r_digits;
    logic [COUNT_WIDTH-1:0] r_written;
    logic [COUNT_WIDTH-1:0] r_source;
    logic [15:0]            r_cap;
    logic [1:0]             r_rem;
    logic [1:0]             r_pos;
    jsu_pkg::t_kind         r_kind;
    logic [2:0][7:0]        r_bytes;
    logic [15:0]            r_len;
    logic [15:0]            r_cons;

    jsu_pkg::t_mode         n_mode;
    logic [15:0]            n_code;
    logic [2:0]             n_digits;
    logic [COUNT_WIDTH-1:0] n_written;
    logic [COUNT_WIDTH-1:0] n_source;
    jsu_pkg::t_bundle       n_bundle;
    logic [15:0]            n_len;
    logic [15:0]            n_cons;

    logic in_fire;
    logic out_fire;
    logic cfg_wr;

    jsu_decode #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_decode (
        .i_mode      (r_mode),
        .i_code      (r_code),
        .i_digits    (r_digits),
        .i_written   (r_written),
        .i_source    (r_source),
        .i_capacity  (r_cap),
        .i_action    (i_s_tuser),
        .i_byte      (i_s_tdata),
        .o_mode      (n_mode),
        .o_code      (n_code),
        .o_digits    (n_digits),
        .o_written   (n_written),
        .o_source    (n_source),
        .o_bundle    (n_bundle),
        .o_out_length(n_len),
        .o_consumed  (n_cons)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == jsu_pkg::REG_CAPACITY[0]);
    assign prdata = (paddr[2] == jsu_pkg::REG_CAPACITY[0]) ? {16'd0, r_cap} : 32'd0;

    assign o_m_tvalid = (r_rem != 2'd0);
    assign out_fire   = o_m_tvalid && i_m_tready;
    assign o_s_tready = (r_rem == 2'd0) || ((r_rem == 2'd1) && i_m_tready);
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign o_m_tuser = r_kind;
    assign o_m_tlast = (r_rem == 2'd1);
    assign o_m_tdata = {r_cons, r_len, r_bytes[r_pos]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= jsu_pkg::CAP_RESET;
        end else if (cfg_wr) begin
            r_cap <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= jsu_pkg::MODE_PLAIN;
            r_code    <= 16'd0;
            r_digits  <= 3'd0;
            r_written <= '0;
            r_source  <= '0;
            r_rem     <= 2'd0;
            r_pos     <= 2'd0;
        end else if (in_fire) begin
            r_mode    <= n_mode;
            r_code    <= n_code;
            r_digits  <= n_digits;
            r_written <= n_written;
            r_source  <= n_source;
            r_rem     <= n_bundle.count;
            r_pos     <= 2'd0;
        end else if (out_fire) begin
            r_rem <= r_rem - 2'd1;
            r_pos <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind  <= n_bundle.kind;
            r_bytes <= n_bundle.bytes;
            r_len   <= n_len;
            r_cons  <= n_cons;
        end
    end

endmodule

`default_nettype wire
